@@ src/sida_pkg.sv @@
`default_nettype none

package sida_pkg;

  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned PIDX_W     = 4;
  localparam int unsigned WIDE_W     = 34;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [WIDE_W-1:0] POW10 [NUM_DIGITS] = '{
    34'd1,
    34'd10,
    34'd100,
    34'd1000,
    34'd10000,
    34'd100000,
    34'd1000000,
    34'd10000000,
    34'd100000000,
    34'd1000000000
  };

  typedef struct packed {
    logic              neg;
    logic [31:0]       mag;
    logic [PIDX_W-1:0] pidx;
  } item_t;

endpackage

`default_nettype wire

@@ src/sida_front.sv @@
`default_nettype none

module sida_front
  import sida_pkg::*;
(
  input  wire logic        start_i,
  input  wire logic        full_i,
  input  wire logic [31:0] number_i,
  output logic             push_o,
  output item_t            item_o
);

  logic                  negative;
  logic [31:0]           mag;
  logic [NUM_DIGITS-1:1] ge;

  assign negative = number_i[31];
  assign mag      = negative ? (~number_i + 32'd1) : number_i;

  // top digit position: count of powers of ten from 10 upward not above the magnitude
  always_comb begin
    for (int k = 1; k < NUM_DIGITS; k++) begin
      ge[k] = {2'b00, mag} >= POW10[k];
    end
  end

  assign push_o      = start_i && !full_i;
  assign item_o.neg  = negative;
  assign item_o.mag  = mag;
  assign item_o.pidx = PIDX_W'($countones(ge));

endmodule

`default_nettype wire

@@ src/sida_fifo.sv @@
`default_nettype none

module sida_fifo
  import sida_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  item_t     item_i,
  input  wire logic pop_i,
  output item_t     item_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign item_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("request pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count out of range");

endmodule

`default_nettype wire

@@ src/sida_back.sv @@
`default_nettype none

module sida_back
  import sida_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       empty_i,
  input  item_t           item_i,
  output logic            pop_o,
  output logic            strobe_o,
  output logic [7:0]      character_o,
  output logic            last_o
);

  logic                  active_q, active_d;
  logic                  sign_q, sign_d;
  logic [31:0]           rem_q, rem_d;
  logic [PIDX_W-1:0]     pidx_q, pidx_d;
  logic                  strobe_q, strobe_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;

  logic [WIDE_W-1:0]     mtab [NUM_DIGITS][NUM_DIGITS];
  logic [WIDE_W-1:0]     mt [NUM_DIGITS];
  logic [NUM_DIGITS-1:1] ge;
  logic [WIDE_W-1:0]     sub;
  logic [3:0]            digit;
  logic                  finishing;

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_mult
    for (genvar p = 0; p < NUM_DIGITS; p++) begin : g_pow
      localparam logic [WIDE_W-1:0] MultC = WIDE_W'(k) * POW10[p];
      assign mtab[k][p] = MultC;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      mt[k] = mtab[k][pidx_q];
    end
    for (int k = 1; k < NUM_DIGITS; k++) begin
      ge[k] = {2'b00, rem_q} >= mt[k];
    end
    sub = '0;
    for (int k = 1; k < NUM_DIGITS; k++) begin
      if (ge[k]) begin
        sub = mt[k];
      end
    end
    digit = 4'($countones(ge));
  end

  assign finishing = active_q && !sign_q && (pidx_q == '0);

  always_comb begin
    active_d = active_q;
    sign_d   = sign_q;
    rem_d    = rem_q;
    pidx_d   = pidx_q;
    strobe_d = 1'b0;
    char_d   = char_q;
    last_d   = 1'b0;
    pop_o    = 1'b0;
    if (active_q) begin
      strobe_d = 1'b1;
      if (sign_q) begin
        char_d = CH_MINUS;
        sign_d = 1'b0;
      end else begin
        char_d = CH_ZERO + {4'b0000, digit};
        rem_d  = rem_q - sub[31:0];
        if (pidx_q == '0) begin
          last_d   = 1'b1;
          active_d = 1'b0;
        end else begin
          pidx_d = pidx_q - PIDX_W'(1);
        end
      end
    end
    // take the next request as soon as the current one issues its last character
    if (!empty_i && (!active_q || finishing)) begin
      pop_o    = 1'b1;
      active_d = 1'b1;
      sign_d   = item_i.neg;
      rem_d    = item_i.mag;
      pidx_d   = item_i.pidx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      sign_q   <= 1'b0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      sign_q   <= sign_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    pidx_q <= pidx_d;
    char_q <= char_d;
  end

  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (pidx_q < PIDX_W'(NUM_DIGITS)) &&
                 ({2'b00, rem_q} < mtab[NUM_DIGITS-1][pidx_q] + POW10[pidx_q]))
    else $error("remainder exceeds digit position");
  a_last_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |-> (character_o >= CH_ZERO) && (character_o <= CH_ZERO + 8'd9))
    else $error("final character is not a digit");
  a_minus_followed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (character_o == CH_MINUS) |=> strobe_o)
    else $error("minus sign not followed by a digit");

endmodule

`default_nettype wire

@@ src/signed_int_to_decimal_ascii.sv @@
`default_nettype none

// Signed 32-bit integer to decimal ASCII text.
// Request channel: drive number_i and raise start; the request is taken at a
// rising edge where start is high and busy is low. busy is high only while the
// request queue of QueueDepth entries (two by default) is full.
// Result channel: one character per cycle on character_o, marked by strobe_o;
// last_o flags the final character of a number. A minus sign precedes
// negative values, leading zeros are dropped, zero gives a single '0'.
// The first character of a request passes the queue entry, the digit unit
// registers and the output register, if the digit unit is free.
// Throughput: a number is 1 to 11 characters long; the digit unit makes one
// digit per cycle from a bank of nine constant compares and one subtract;
// characters of consecutive numbers follow without gaps if the next is queued.
// The receiver cannot stall: each character shows for exactly one cycle.
// Reset empties the queue and idles the digit unit; no result is pending.
module signed_int_to_decimal_ascii
  import sida_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] number_i,
  output logic                    strobe_o,
  output logic             [7:0]  character_o,
  output logic                    last_o
);

  logic  push;
  logic  pop;
  logic  empty;
  logic  full;
  item_t front_item;
  item_t queue_item;

  assign busy = full;

  sida_front u_front (
    .start_i  (start),
    .full_i   (full),
    .number_i (number_i),
    .push_o   (push),
    .item_o   (front_item)
  );

  sida_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (empty),
    .full_o  (full)
  );

  sida_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (queue_item),
    .pop_o       (pop),
    .strobe_o    (strobe_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
